/* design/gtp_pkg.sv */
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared constants and pipeline types for the tanh-form GELU unit.
// ----------------------------------------------------------------------------
package gtp_pkg;

  // Internal fraction width of the inner datapath.
  localparam int IQ = 28;

  // Pipeline depth of each section.
  localparam int POLY_ST = 8;
  localparam int DIV_ST  = 10;
  localparam int OUT_ST  = 2;
  localparam int NST     = POLY_ST + DIV_ST + OUT_ST;

  // Divider geometry: quotient bits, remainder width, bits per stage.
  localparam int QW  = 30;
  localparam int RW  = 38;
  localparam int NW  = 36;
  localparam int BPS = QW / DIV_ST;

  localparam logic [28:0] ONE_Q  = 29'd1 << IQ;
  localparam logic [27:0] C1_Q   = 28'd214180506;  // sqrt(2/pi)
  localparam logic [23:0] C2_Q   = 24'd12003091;   // 0.044715
  localparam logic [29:0] TH_Q   = 30'd885837005;  // 3.3

  localparam logic [30:0] N1_K   = 31'd17325 << 16;
  localparam logic [27:0] D1_K   = 28'd3150 << 16;
  localparam logic [32:0] D2_K   = 33'd62370 << 16;
  localparam logic [37:0] K0_K   = 38'd135135 << 16;

  // Side information that rides along with each item.
  typedef struct packed {
    logic        neg;   // input was negative
    logic        big;   // |x| >= 4.0, result bypasses the math
    logic        sat;   // inner above 3.3, tanh forced to one
    logic [31:0] x;     // raw input beat
    logic [29:0] iv;    // inner magnitude, Q28
  } side_t;

  // One divider stage.
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] dq;   // dividend bits still to shift in, quotient bits behind
    logic [RW-1:0] den;
    side_t         sd;
  } div_st_t;

endpackage

/* design/gtp_poly.sv */
// ----------------------------------------------------------------------------
// gtp_poly
// Front pipeline: magnitude, cubic, inner argument, u and the Pade terms.
// ----------------------------------------------------------------------------
module gtp_poly #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic [gtp_pkg::POLY_ST-1:0]     en,
  input  logic [31:0]                     x_i,
  output gtp_pkg::side_t                  sd_o,
  output logic [gtp_pkg::NW-1:0]          num_o,
  output logic [gtp_pkg::RW-1:0]          den_o
);
  import gtp_pkg::*;

  localparam int MW = FRAC_BITS + 2;

  // stage 0
  logic [31:0] mag;
  logic        neg_r, big_r;
  logic [31:0] x_r;
  logic [29:0] a28_r0;

  // stages 1..4
  logic [59:0] p1;
  logic [31:0] a2_r;
  logic [29:0] a28_r1, a28_r2, a28_r3;
  side_t       sd_r1, sd_r2, sd_r3, sd_r4;
  logic [61:0] p2;
  logic [33:0] a3_r;
  logic [57:0] p3;
  logic [29:0] cub_r;
  logic [30:0] sum;
  logic [58:0] p4;
  logic [30:0] inner_r;

  // stages 5..7
  logic [59:0] p5;
  logic [19:0] u_r5, u_r6;
  side_t       sd_r5, sd_r6, sd_r7;
  logic [30:0] n1;
  logic [27:0] d1;
  logic [50:0] pn;
  logic [47:0] pd1;
  logic [NW-1:0] num_r6, num_r7;
  logic [32:0] d2_r;
  logic [52:0] pd2;
  logic [RW-1:0] den_r;

  assign mag = x_i[31] ? (32'd0 - x_i) : x_i;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r    <= x_i;
      neg_r  <= x_i[31];
      big_r  <= (mag >= (32'd4 << FRAC_BITS));
      a28_r0 <= {mag[MW-1:0], {(IQ - FRAC_BITS){1'b0}}};
    end
  end

  assign p1 = a28_r0 * a28_r0;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a2_r       <= 32'((p1 + (60'd1 << (IQ - 1))) >> IQ);
      a28_r1     <= a28_r0;
      sd_r1.neg  <= neg_r;
      sd_r1.big  <= big_r;
      sd_r1.sat  <= 1'b0;
      sd_r1.x    <= x_r;
      sd_r1.iv   <= '0;
    end
  end

  assign p2 = a2_r * a28_r1;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a3_r   <= 34'((p2 + (62'd1 << (IQ - 1))) >> IQ);
      a28_r2 <= a28_r1;
      sd_r2  <= sd_r1;
    end
  end

  assign p3 = C2_Q * a3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cub_r  <= 30'((p3 + (58'd1 << (IQ - 1))) >> IQ);
      a28_r3 <= a28_r2;
      sd_r3  <= sd_r2;
    end
  end

  assign sum = 31'(a28_r3) + 31'(cub_r);
  assign p4  = C1_Q * sum;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      inner_r <= 31'((p4 + (59'd1 << (IQ - 1))) >> IQ);
      sd_r4   <= sd_r3;
    end
  end

  // u = inner^2 in Q16; only meaningful when not saturated
  assign p5 = inner_r[29:0] * inner_r[29:0];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      u_r5      <= 20'((p5 + (60'd1 << 39)) >> 40);
      sd_r5.neg <= sd_r4.neg;
      sd_r5.big <= sd_r4.big;
      sd_r5.x   <= sd_r4.x;
      sd_r5.sat <= (inner_r > 31'(TH_Q));
      sd_r5.iv  <= inner_r[29:0];
    end
  end

  assign n1  = 31'(u_r5 * 9'd378) + N1_K;
  assign d1  = 28'(u_r5 * 5'd28) + D1_K;
  assign pn  = n1 * u_r5;
  assign pd1 = d1 * u_r5;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      num_r6 <= NW'((pn + 51'd32768) >> 16) + NW'(K0_K);
      d2_r   <= 33'((pd1 + 48'd32768) >> 16) + D2_K;
      u_r6   <= u_r5;
      sd_r6  <= sd_r5;
    end
  end

  assign pd2 = d2_r * u_r6;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      den_r  <= RW'((pd2 + 53'd32768) >> 16) + K0_K;
      num_r7 <= num_r6;
      sd_r7  <= sd_r6;
    end
  end

  assign sd_o  = sd_r7;
  assign num_o = num_r7;
  assign den_o = den_r;

endmodule

/* design/gtp_div.sv */
// ----------------------------------------------------------------------------
// gtp_div
// Pipelined restoring divider: r = rnd(num * 2^28 / den), a few bits a stage.
// ----------------------------------------------------------------------------
module gtp_div (
  input  logic                          clk,
  input  logic [gtp_pkg::DIV_ST-1:0]    en,
  input  logic [gtp_pkg::NW-1:0]        num_i,
  input  logic [gtp_pkg::RW-1:0]        den_i,
  input  gtp_pkg::side_t                sd_i,
  output logic [gtp_pkg::QW-1:0]        q_o,
  output gtp_pkg::side_t                sd_o
);
  import gtp_pkg::*;

  logic [63:0] dvd;
  div_st_t     st_in  [DIV_ST];
  div_st_t     st_nxt [DIV_ST];
  div_st_t     st_r   [DIV_ST];

  // Rounding folded into the dividend; quotient stays below 2^QW so the
  // top bits already sit below den.
  assign dvd = {num_i, {IQ{1'b0}}} + 64'(den_i >> 1);

  genvar g;
  generate
    for (g = 0; g < DIV_ST; g++) begin : g_stage
      if (g == 0) begin : g_first
        assign st_in[g].rem = RW'(dvd[63:QW]);
        assign st_in[g].dq  = dvd[QW-1:0];
        assign st_in[g].den = den_i;
        assign st_in[g].sd  = sd_i;
      end else begin : g_next
        assign st_in[g] = st_r[g-1];
      end

      always_comb begin : step
        div_st_t     s;
        logic [RW:0] tr;
        logic        ge;
        s = st_in[g];
        for (int j = 0; j < BPS; j++) begin
          tr    = {s.rem, s.dq[QW-1]};
          ge    = (tr >= {1'b0, s.den});
          s.dq  = {s.dq[QW-2:0], ge};
          s.rem = ge ? RW'(tr - {1'b0, s.den}) : tr[RW-1:0];
        end
        st_nxt[g] = s;
      end

      always_ff @(posedge clk) begin
        if (en[g]) begin
          st_r[g] <= st_nxt[g];
        end
      end
    end
  endgenerate

  assign q_o  = st_r[DIV_ST-1].dq;
  assign sd_o = st_r[DIV_ST-1].sd;

endmodule

/* design/gtp_out.sv */
// ----------------------------------------------------------------------------
// gtp_out
// Back end: tanh from the ratio, 1 +- tanh, final scale, sign and bypass.
// ----------------------------------------------------------------------------
module gtp_out (
  input  logic                          clk,
  input  logic [gtp_pkg::OUT_ST-1:0]    en,
  input  logic [gtp_pkg::QW-1:0]        q_i,
  input  gtp_pkg::side_t                sd_i,
  output logic [31:0]                   y_o
);
  import gtp_pkg::*;

  logic [59:0] pt;
  logic [31:0] traw;
  logic [28:0] t;
  logic [29:0] f_r;
  side_t       sd_r;
  logic [31:0] mag;
  logic [61:0] py;
  logic [31:0] ym;
  logic [31:0] y_r;

  assign pt   = sd_i.iv * q_i;
  assign traw = 32'((pt + (60'd1 << (IQ - 1))) >> IQ);
  assign t    = (sd_i.sat || (traw > 32'(ONE_Q))) ? ONE_Q : traw[28:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f_r  <= sd_i.neg ? (30'(ONE_Q) - 30'(t)) : (30'(ONE_Q) + 30'(t));
      sd_r <= sd_i;
    end
  end

  assign mag = sd_r.neg ? (32'd0 - sd_r.x) : sd_r.x;
  assign py  = mag * f_r;
  assign ym  = 32'((py + (62'd1 << (IQ - 1))) >> (IQ + 1));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (sd_r.big) begin
        y_r <= sd_r.neg ? 32'd0 : sd_r.x;
      end else begin
        y_r <= sd_r.neg ? (32'd0 - ym) : ym;
      end
    end
  end

  assign y_o = y_r;

endmodule

/* design/gelu_tanh_pade_activation_unit.sv */
// ----------------------------------------------------------------------------
// gelu_tanh_pade_activation_unit
// GELU (tanh form, Pade tanh) on signed fixed-point activations.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per activation, in_tdata = x_value (signed, FRAC_BITS
//           fraction bits). Accepted when in_tvalid && in_tready.
//   out_* : one beat per input beat, same order, out_tdata = y_value.
//   Throughput: one beat per cycle, sustained, when out_tready stays high.
//   Depth: 20 register stages, set by the three-bits-per-stage quotient
//   divider (10 stages) plus the front and back pipelines. Each stage has
//   its own valid bit and advances when it is empty or the stage after it
//   advances, so bubbles close up and in_tready stays high while any stage
//   is free, even with a result waiting at the output. A receiver stall
//   holds each full stage with no free stage after it; nothing is dropped
//   or doubled.
//   Reset (rst_n low, synchronous) clears every valid bit, emptying the pipe.
//   Inputs with |x| >= 4.0 bypass the math: x for positive, 0 for negative.
// ----------------------------------------------------------------------------
module gelu_tanh_pade_activation_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] x_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] y_value
);
  import gtp_pkg::*;

  logic [NST-1:0]    v_r;
  logic [NST-1:0]    en;
  side_t             sd_p, sd_d;
  logic [NW-1:0]     num;
  logic [RW-1:0]     den;
  logic [QW-1:0]     q;

  // Stage advance chain, from the output back to the input.
  assign en[NST-1] = !v_r[NST-1] || out_tready;
  genvar i;
  generate
    for (i = 0; i < NST - 1; i++) begin : g_en
      assign en[i] = !v_r[i] || en[i+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NST-1];

  gtp_poly #(
    .FRAC_BITS(FRAC_BITS)
  ) u_poly (
    .clk  (clk),
    .en   (en[POLY_ST-1:0]),
    .x_i  (in_tdata),
    .sd_o (sd_p),
    .num_o(num),
    .den_o(den)
  );

  gtp_div u_div (
    .clk  (clk),
    .en   (en[POLY_ST+DIV_ST-1:POLY_ST]),
    .num_i(num),
    .den_i(den),
    .sd_i (sd_p),
    .q_o  (q),
    .sd_o (sd_d)
  );

  gtp_out u_out (
    .clk (clk),
    .en  (en[NST-1:POLY_ST+DIV_ST]),
    .q_i (q),
    .sd_i(sd_d),
    .y_o (out_tdata)
  );

  // Input only blocks when every stage holds a beat.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input blocked with an empty stage");

  // Beats in flight change only by accepts on either side.
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $past($countones(v_r))
      + int'($past(in_tvalid && in_tready)) - int'($past(out_tvalid && out_tready))))
    else $error("beat lost or duplicated in pipeline");

  // GELU never goes below about -0.17, so a valid result is above -1.0.
  a_out_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) > -(32'sd1 <<< FRAC_BITS)))
    else $error("result below GELU minimum");

endmodule

/* bench/gelu_tanh_pade_activation_unit_tb.sv */
// ----------------------------------------------------------------------------
// gelu_tanh_pade_activation_unit_tb
// Drives activations into the GELU unit, predicts every output beat with an
// independent fixed-point GELU model and compares in order, under varied
// sender idling and receiver backpressure.
// ----------------------------------------------------------------------------
module gelu_tanh_pade_activation_unit_tb;

  localparam int FRAC = 16;
  localparam int LAT  = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  gelu_tanh_pade_activation_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  logic [31:0] pending_x[$];
  logic [31:0] gelu_expected[$];
  int          err_cnt = 0;
  int          beats_out = 0;
  int          send_idle_pct = 0;   // percent of cycles the sender idles
  int          recv_stall_pct = 0;  // percent of cycles the receiver stalls
  int          hold_cycles = 0;     // long receiver hold-off, counted down
  bit          hold_req = 1'b0;

  // acceptance seen at the last rising edge
  logic in_tready_q = 1'b0;

  // rounded product shift, all operands non-negative
  function automatic logic [63:0] mrnd(logic [63:0] p, logic [63:0] q, int sh);
    return (p * q + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [63:0] tanh_q28(logic [63:0] v);
    logic [63:0] u, num, den, r, t;
    if (v > (64'd4 << 28)) v = 64'd4 << 28;
    if (v > 64'd885837005) return 64'd1 << 28;
    u   = mrnd(v, v, 40);
    num = mrnd(378 * u + (64'd17325 << 16), u, 16) + (64'd135135 << 16);
    den = mrnd(28 * u + (64'd3150 << 16), u, 16) + (64'd62370 << 16);
    den = mrnd(den, u, 16) + (64'd135135 << 16);
    r   = ((num << 28) + (den >> 1)) / den;
    t   = mrnd(v, r, 28);
    if (t > (64'd1 << 28)) t = 64'd1 << 28;
    return t;
  endfunction

  function automatic logic [31:0] gelu_fix(logic [31:0] x);
    logic        neg;
    logic [63:0] mag, a28, a2, a3, cub, inner, t, f, ym;
    neg = x[31];
    mag = neg ? {32'd0, 32'd0 - x} : {32'd0, x};
    if (neg && x == 32'h8000_0000) mag = 64'd1 << 31;
    // large magnitude: tanh saturated, pass x or zero
    if (mag >= (64'd4 << FRAC)) return neg ? 32'd0 : x;
    a28   = mag << (28 - FRAC);
    a2    = mrnd(a28, a28, 28);
    a3    = mrnd(a2, a28, 28);
    cub   = mrnd(64'd12003091, a3, 28);
    inner = mrnd(64'd214180506, a28 + cub, 28);
    t     = tanh_q28(inner);
    f     = neg ? ((64'd1 << 28) - t) : ((64'd1 << 28) + t);
    ym    = (mag * f + (64'd1 << 27)) >> 29;
    return neg ? 32'd0 - ym[31:0] : ym[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("mismatch %s: got %h expected %h at beat %0d", what, got, exp_v, beats_out);
    err_cnt++;
  endtask

  // driver: next beat changes on the falling edge, once current one is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready_q) begin
        if (pending_x.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= pending_x.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (hold_cycles > 0) out_tready <= 1'b0;
      else out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      in_tready_q <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) gelu_expected.push_back(gelu_fix(in_tdata));
      if (out_tvalid && out_tready) begin
        beats_out++;
        if (gelu_expected.size() == 0) report_mismatch("unexpected beat", out_tdata, 'x);
        else begin
          logic [31:0] e;
          e = gelu_expected.pop_front();
          if (out_tdata !== e) report_mismatch("y_value", out_tdata, e);
        end
      end
    end else in_tready_q <= 1'b0;
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (!rst_n) hold_cycles <= 0;
    else if (hold_req) hold_cycles <= 400;
    else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  task automatic wait_drained();
    while (pending_x.size() > 0 || in_tvalid || gelu_expected.size() > 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_x();
    int k;
    k = $urandom_range(9);
    if (k < 6) return $urandom_range(32'h0009_0000) - 32'h0004_8000;   // math region and just past it
    if (k < 8) return $signed($urandom_range(32'h0000_FFFF)) - 32'sh8000; // near zero
    return $urandom();
  endfunction

  initial begin
    logic [31:0] dir[$];
    dir = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0001, 32'h0004_0000, 32'hFFFC_0000, 32'h0003_FFFF, 32'hFFFC_0001,
            32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0003_4CCD,
            32'hFFFC_B333, 32'h0000_8000, 32'hFFFF_8000, 32'h5555_5555, 32'hAAAA_AAAA};
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    foreach (dir[i]) pending_x.push_back(dir[i]);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 33 : 0;
      recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 33 : 0;
      for (int i = 0; i < 450; i++) pending_x.push_back(rand_x());
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering beats
        @(negedge clk) hold_req = 1'b1;
        @(negedge clk) hold_req = 1'b0;
      end
      wait_drained();  // sender pauses until all results are back
    end
    for (int i = 0; i < 130; i++) pending_x.push_back($urandom());
    wait_drained();
    $display("covered %0d output beats: extremes, bypass region, tanh clamp, four pacing phases",
             beats_out);
    if (err_cnt == 0) $display("gelu_tanh_pade_activation_unit_tb: PASS");
    else $display("gelu_tanh_pade_activation_unit_tb: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("gelu_tanh_pade_activation_unit_tb: FAIL");
    $finish;
  end

endmodule
